/* design/csht_pkg.sv */
package csht_pkg;

	localparam int KEY_W   = 22;
	localparam int HIGH_W  = 64;
	localparam int LOW_W   = 24;
	localparam int AGE_W   = 8;
	localparam int NAME_BYTES = 11;
	localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd10;
	localparam logic [AGE_W-1:0] AGE_TOP     = 8'hFF;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_SAVE   = 2'd1,
		OP_AGE    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FULL  = 2'd0,
		KIND_TOP12 = 2'd1,
		KIND_TOP10 = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [HIGH_W-1:0] name_high;
		logic [LOW_W-1:0]  name_low;
		logic [AGE_W-1:0]  age;
	} entry_t;

	typedef struct packed {
		logic start;
		logic clr_wr;
		logic rd;
		logic save_wr;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic cnt_done;
		logic rd_pending;
		logic hit;
		logic is_save;
		logic out_free;
	} dp_sts_t;

	// Zero every byte after the first zero byte of the 11-byte name.
	function automatic logic [HIGH_W+LOW_W-1:0] pad_name(
		input logic [HIGH_W-1:0] nh,
		input logic [LOW_W-1:0]  nl
	);
		logic [HIGH_W+LOW_W-1:0] name;
		logic ended;
		name = {nh, nl};
		ended = 1'b0;
		for (int i = NAME_BYTES - 1; i >= 0; i--) begin
			if (ended) begin
				name[i*8 +: 8] = 8'h00;
			end else if (name[i*8 +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return name;
	endfunction

	function automatic logic key_hits(
		input logic [KEY_W-1:0] stored,
		input logic [1:0]       kind,
		input logic [KEY_W-1:0] key
	);
		logic hit;
		case (kind)
			KIND_FULL:  hit = (stored == key);
			KIND_TOP12: hit = (stored[KEY_W-1:10] == key[11:0]);
			default:    hit = (stored[KEY_W-1:12] == key[9:0]);
		endcase
		return hit;
	endfunction

endpackage

/* design/callsign_hash_table_with_aging_core.sv */
// A lookup or age tick scans the entries before its result is loaded (a lookup stops early on
// a hit); a save then needs an extra write state, S_WRITE, before its result is loaded.
// One transaction at a time: the next is accepted in the cycle after the result is loaded into
// the output register; a stalled result holds the following transaction in its finishing
// state until it drains.
// After reset a clearing pass marks every entry invalid; max_age resets to 10.
module callsign_hash_table_with_aging_core #(
	parameter int ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [1:0]  hash_kind,
	input  logic [21:0] key,
	input  logic [63:0] name_high,
	input  logic [23:0] name_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] found_high,
	output logic [23:0] found_low,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	csht_pkg::ctrl_cmd_t cmd;
	csht_pkg::dp_sts_t   sts;

	csht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csht_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.opcode     (opcode),
		.hash_kind  (hash_kind),
		.key        (key),
		.name_high  (name_high),
		.name_low   (name_low),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.found_high (found_high),
		.found_low  (found_low)
	);

endmodule

/* design/csht_ctrl.sv */
module csht_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  csht_pkg::dp_sts_t   sts,
	output csht_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_SCAN   = 5'b00100,
		S_WRITE  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		in_stall = 1'b1;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.cnt_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd = !sts.cnt_done && !sts.hit;
				if (!sts.rd_pending && (sts.cnt_done || sts.hit)) begin
					state_d = sts.is_save ? S_WRITE : S_FINISH;
				end
			end
			S_WRITE: begin
				cmd.save_wr = 1'b1;
				state_d     = S_FINISH;
			end
			S_FINISH: begin
				// hold until the output register can take the result
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/csht_datapath.sv */
module csht_datapath #(
	parameter int ENTRIES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csht_pkg::ctrl_cmd_t cmd,
	output csht_pkg::dp_sts_t   sts,
	input  logic [1:0]          opcode,
	input  logic [1:0]          hash_kind,
	input  logic [21:0]         key,
	input  logic [63:0]         name_high,
	input  logic [23:0]         name_low,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic [63:0]         found_high,
	output logic [23:0]         found_low
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ENTRIES - 1);

	csht_pkg::entry_t mem [ENTRIES];

	logic [1:0]  op_q, kind_q;
	logic [21:0] key_q;
	logic [63:0] nh_q;
	logic [23:0] nl_q;
	logic [7:0]  max_age_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] cnt_idx;

	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	csht_pkg::entry_t rd_data_s1;

	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [63:0]      hit_high_q;
	logic [23:0]      hit_low_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [63:0]      found_high_q;
	logic [23:0]      found_low_q;

	logic             match;
	logic [7:0]       age_inc;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	csht_pkg::entry_t wr_data;
	logic [87:0]      padded;
	logic [1:0]       status_d;

	assign cnt_idx = cnt_q[IDX_W-1:0];
	assign padded  = csht_pkg::pad_name(name_high, name_low);

	always_comb begin
		case (csht_pkg::op_t'(op_q))
			csht_pkg::OP_LOOKUP: match = rd_data_s1.valid &&
				csht_pkg::key_hits(rd_data_s1.key, kind_q, key_q);
			csht_pkg::OP_SAVE:   match = rd_data_s1.valid && (rd_data_s1.key == key_q);
			default:             match = 1'b0;
		endcase
	end

	assign age_inc = (rd_data_s1.age == csht_pkg::AGE_TOP) ? rd_data_s1.age
		: rd_data_s1.age + 8'd1;

	// memory write port: clearing pass, age write-back, save
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_idx;
		wr_data = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (rd_vld_s1 && op_q == csht_pkg::OP_AGE && rd_data_s1.valid) begin
			wr_en         = 1'b1;
			wr_addr       = rd_idx_s1;
			wr_data       = rd_data_s1;
			wr_data.age   = age_inc;
			wr_data.valid = !(age_inc > max_age_q);
		end else if (cmd.save_wr && (hit_q || free_q)) begin
			wr_en             = 1'b1;
			wr_addr           = hit_q ? hit_idx_q : free_idx_q;
			wr_data.valid     = 1'b1;
			wr_data.key       = key_q;
			wr_data.name_high = nh_q;
			wr_data.name_low  = nl_q;
			wr_data.age       = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_data_s1 <= mem[cnt_idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q   <= opcode;
			kind_q <= hash_kind;
			key_q  <= key;
			nh_q   <= padded[87:24];
			nl_q   <= padded[23:0];
		end
		if (cmd.rd) rd_idx_s1 <= cnt_idx;
		if (rd_vld_s1 && !hit_q && match) begin
			hit_idx_q  <= rd_idx_s1;
			hit_high_q <= rd_data_s1.name_high;
			hit_low_q  <= rd_data_s1.name_low;
		end
		if (rd_vld_s1 && !free_q && !rd_data_s1.valid) free_idx_q <= rd_idx_s1;
		if (cmd.load_out) begin
			status_q     <= status_d;
			found_high_q <= (op_q == csht_pkg::OP_LOOKUP && hit_q) ? hit_high_q : '0;
			found_low_q  <= (op_q == csht_pkg::OP_LOOKUP && hit_q) ? hit_low_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			max_age_q   <= csht_pkg::MAX_AGE_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.clr_wr || cmd.rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			rd_vld_s1 <= cmd.rd;
			if (cmd.start) begin
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (rd_vld_s1) begin
				if (match) hit_q <= 1'b1;
				if (!rd_data_s1.valid) free_q <= 1'b1;
			end
			if (cfg_we) max_age_q <= cfg_wdata;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (csht_pkg::op_t'(op_q))
			csht_pkg::OP_LOOKUP: status_d = hit_q ? csht_pkg::ST_OK : csht_pkg::ST_MISS;
			csht_pkg::OP_SAVE:   status_d = (hit_q || free_q) ? csht_pkg::ST_OK
				: csht_pkg::ST_FULL;
			default:             status_d = csht_pkg::ST_OK;
		endcase
	end

	assign sts.cnt_last   = (cnt_q == CNT_LAST);
	assign sts.cnt_done   = (cnt_q == CNT_END);
	assign sts.rd_pending = rd_vld_s1;
	assign sts.hit        = hit_q;
	assign sts.is_save    = (op_q == csht_pkg::OP_SAVE);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found_high = found_high_q;
	assign found_low  = found_low_q;

`ifndef SYNTHESIS
	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.load_out))
		else $error("result appeared without a load");
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && cmd.rd) |-> (wr_addr != cnt_idx))
		else $error("read and write hit the same entry");
	a_no_load_over_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> !$rose(out_valid_q) && $stable(status_q))
		else $error("stalled result overwritten");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !sts.cnt_done)
		else $error("read issued past the last entry");
`endif

endmodule

/* tb/sv/tb_callsign_hash_table_with_aging_core.sv */
`timescale 1ns / 1ps

module tb_callsign_hash_table_with_aging_core;
	import csht_pkg::*;

	localparam int ENTRIES      = 256;
	localparam int CYCLE_LIMIT  = 4000000;
	localparam int SETTLE_CYCLES = ENTRIES + 40;
	localparam int HOLD_CYCLES  = 3000;
	localparam int NAME_W       = HIGH_W + LOW_W;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct {
		status_t           st;
		logic [HIGH_W-1:0] fh;
		logic [LOW_W-1:0]  fl;
	} table_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        opcode     = '0;
	logic [1:0]        hash_kind  = '0;
	logic [KEY_W-1:0]  key        = '0;
	logic [HIGH_W-1:0] name_high  = '0;
	logic [LOW_W-1:0]  name_low   = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [1:0]        status;
	logic [HIGH_W-1:0] found_high;
	logic [LOW_W-1:0]  found_low;
	logic              cfg_we     = 1'b0;
	logic [AGE_W-1:0]  cfg_wdata  = '0;

	// Shadow copy of the table and its aging limit
	logic              tbl_valid [ENTRIES];
	logic [KEY_W-1:0]  tbl_key   [ENTRIES];
	logic [HIGH_W-1:0] tbl_hi    [ENTRIES];
	logic [LOW_W-1:0]  tbl_lo    [ENTRIES];
	logic [AGE_W-1:0]  tbl_age   [ENTRIES];
	logic [AGE_W-1:0]  shadow_max_age = MAX_AGE_RST;

	table_result_t pending_results [$];
	logic [9:0]    key_roots [6];

	int  errors      = 0;
	int  cycle_count = 0;
	int  hold_cycles = 0;
	bit  idle_on     = 1'b1;
	int  n_lookup = 0, n_hit = 0, n_save = 0, n_full = 0, n_tick = 0, n_nop = 0;

	callsign_hash_table_with_aging_core #(
		.ENTRIES(ENTRIES)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.hash_kind (hash_kind),
		.key       (key),
		.name_high (name_high),
		.name_low  (name_low),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.found_high(found_high),
		.found_low (found_low),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic prefix_match(
		input logic [KEY_W-1:0] stored,
		input logic [1:0]       kind,
		input logic [KEY_W-1:0] k
	);
		if (kind == KIND_FULL)
			return stored == k;
		if (kind == KIND_TOP12)
			return stored[21:10] == k[11:0];
		return stored[21:12] == k[9:0];
	endfunction

	function automatic table_result_t apply_table_op(
		input logic [1:0]        op,
		input logic [1:0]        kind,
		input logic [KEY_W-1:0]  k,
		input logic [HIGH_W-1:0] nh,
		input logic [LOW_W-1:0]  nl
	);
		table_result_t r;
		logic [NAME_W-1:0] name;
		logic ended;
		int slot;
		r.st = ST_OK;
		r.fh = '0;
		r.fl = '0;
		slot = -1;
		case (op)
			OP_LOOKUP: begin
				n_lookup++;
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && tbl_valid[i] && prefix_match(tbl_key[i], kind, k))
						slot = i;
				if (slot < 0) begin
					r.st = ST_MISS;
				end else begin
					n_hit++;
					r.fh = tbl_hi[slot];
					r.fl = tbl_lo[slot];
				end
			end
			OP_SAVE: begin
				n_save++;
				// Clear everything past the first zero byte, byte 0 on top
				name = {nh, nl};
				ended = 1'b0;
				for (int b = 0; b < NAME_BYTES; b++) begin
					if (ended)
						name[(NAME_BYTES-1-b)*8 +: 8] = 8'h00;
					else if (name[(NAME_BYTES-1-b)*8 +: 8] == 8'h00)
						ended = 1'b1;
				end
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && tbl_valid[i] && tbl_key[i] == k)
						slot = i;
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !tbl_valid[i])
						slot = i;
				if (slot < 0) begin
					n_full++;
					r.st = ST_FULL;
				end else begin
					tbl_valid[slot] = 1'b1;
					tbl_key[slot]   = k;
					tbl_hi[slot]    = name[NAME_W-1:LOW_W];
					tbl_lo[slot]    = name[LOW_W-1:0];
					tbl_age[slot]   = '0;
				end
			end
			OP_AGE: begin
				n_tick++;
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i]) begin
						if (tbl_age[i] != AGE_TOP)
							tbl_age[i] = tbl_age[i] + 1'b1;
						if (tbl_age[i] > shadow_max_age)
							tbl_valid[i] = 1'b0;
					end
				end
			end
			default: n_nop++;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [NAME_W-1:0] rand_name();
		logic [NAME_W-1:0] n;
		n = {$urandom, $urandom, 24'($urandom)};
		// Plant a terminator now and then
		if ($urandom_range(0, 2) == 0)
			n[$urandom_range(0, NAME_BYTES-1)*8 +: 8] = 8'h00;
		return n;
	endfunction

	// Few roots and a small low pool so that keys and prefixes collide
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom);
		k[21:12] = key_roots[$urandom_range(0, 5)];
		if ($urandom_range(0, 1) == 0)
			k[9:0] = 10'($urandom_range(0, 7));
		return k;
	endfunction

	task automatic send_op(
		input logic [1:0]        op,
		input logic [1:0]        kind,
		input logic [KEY_W-1:0]  k,
		input logic [HIGH_W-1:0] nh,
		input logic [LOW_W-1:0]  nl
	);
		int gap;
		@(negedge clk);
		in_valid  = 1'b1;
		opcode    = op;
		hash_kind = kind;
		key       = k;
		name_high = nh;
		name_low  = nl;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(apply_table_op(op, kind, k, nh, nl));
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_all_done();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_max_age(input logic [AGE_W-1:0] v);
		wait_all_done();
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		shadow_max_age = v;
	endtask

	task automatic send_save(input logic [KEY_W-1:0] k);
		logic [NAME_W-1:0] n;
		n = rand_name();
		send_op(OP_SAVE, 2'($urandom_range(0, 3)), k, n[NAME_W-1:LOW_W], n[LOW_W-1:0]);
	endtask

	task automatic send_lookup();
		logic [1:0]       kind;
		logic [KEY_W-1:0] k;
		logic [KEY_W-1:0] stored;
		int start;
		int slot;
		kind = 2'($urandom_range(0, 3));
		k = KEY_W'($urandom);
		start = $urandom_range(0, ENTRIES-1);
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && tbl_valid[(start + i) % ENTRIES])
				slot = (start + i) % ENTRIES;
		if (slot >= 0 && $urandom_range(0, 9) < 7) begin
			stored = tbl_key[slot];
			if (kind == KIND_FULL)
				k = stored;
			else if (kind == KIND_TOP12)
				k[11:0] = stored[21:10];
			else
				k[9:0] = stored[21:12];
		end else if ($urandom_range(0, 1) == 0) begin
			k = rand_key();
		end
		send_op(OP_LOOKUP, kind, k, {$urandom, $urandom}, 24'($urandom));
	endtask

	task automatic send_random_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			send_save(rand_key());
		else if (r < 85)
			send_lookup();
		else if (r < 97)
			send_op(OP_AGE, 2'($urandom_range(0, 3)), 22'($urandom), {$urandom, $urandom},
				24'($urandom));
		else
			send_op(OP_NOP, 2'($urandom_range(0, 3)), 22'($urandom), {$urandom, $urandom},
				24'($urandom));
	endtask

	task automatic test_directed();
		logic [KEY_W-1:0] ka, kb;
		ka = 22'h2AAAAA;
		kb = 22'h155555;
		send_op(OP_LOOKUP, KIND_FULL, '0, '0, '0);
		send_op(OP_SAVE, KIND_FULL, '0, '1, '1);
		send_op(OP_SAVE, KIND_FULL, '1, '0, '0);
		send_op(OP_SAVE, KIND_TOP12, ka, 64'h41424300_45464748, 24'h494A4B);
		send_op(OP_SAVE, KIND_TOP10, kb, 64'h4B314142_43444546, 24'h47004A);
		send_op(OP_LOOKUP, KIND_FULL, '0, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, '1, '1, '1);
		send_op(OP_LOOKUP, KIND_TOP12, {10'h155, ka[21:10]}, '0, '0);
		send_op(OP_LOOKUP, KIND_TOP10, {12'hFFF, kb[21:12]}, '0, '0);
		send_op(OP_LOOKUP, KIND_SPARE, {12'h000, 10'h3FF}, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, 22'h123456, '0, '0);
		send_op(OP_NOP, KIND_SPARE, '1, '1, '1);
		send_op(OP_SAVE, KIND_FULL, '0, 64'h5A5A_0000_1234_5678, 24'hA5A5A5);
		send_op(OP_LOOKUP, KIND_FULL, '0, '0, '0);
		send_op(OP_AGE, KIND_FULL, '0, '0, '0);
		send_op(OP_LOOKUP, KIND_TOP12, 22'h000123, '0, '0);
		send_op(OP_SAVE, KIND_SPARE, '0, '1, '1);
		send_op(OP_LOOKUP, KIND_TOP12, '1, '0, '0);
		send_op(OP_NOP, KIND_FULL, '0, '0, '0);
		send_op(OP_AGE, KIND_SPARE, '1, '1, '1);
		send_op(OP_LOOKUP, KIND_FULL, ka, '0, '0);
	endtask

	// Zero limit: one tick drops everything
	task automatic test_drop_at_zero();
		set_max_age(8'd0);
		send_save(22'h0ABCDE);
		send_save(22'h3F0F0F);
		send_op(OP_LOOKUP, KIND_FULL, 22'h0ABCDE, '0, '0);
		send_op(OP_AGE, KIND_FULL, '0, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, 22'h0ABCDE, '0, '0);
		send_op(OP_LOOKUP, KIND_TOP10, 22'h0003F0, '0, '0);
	endtask

	// Ages pin at the top with limit 255, then one tick under 254 drops them
	task automatic test_age_saturation();
		set_max_age(8'd255);
		send_save(22'h2468AC);
		send_save(22'h13579B);
		repeat (258) send_op(OP_AGE, KIND_FULL, '0, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, 22'h2468AC, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, 22'h13579B, '0, '0);
		set_max_age(8'd254);
		send_op(OP_AGE, KIND_FULL, '0, '0, '0);
		send_op(OP_LOOKUP, KIND_FULL, 22'h2468AC, '0, '0);
		send_op(OP_LOOKUP, KIND_TOP12, {10'h0, 12'h135}, '0, '0);
	endtask

	task automatic test_table_full();
		logic [KEY_W-1:0] k;
		set_max_age(8'd0);
		send_op(OP_AGE, KIND_FULL, '0, '0, '0);
		set_max_age(8'd255);
		for (int i = 0; i < ENTRIES + 14; i++) begin
			k = {10'(i * 37), 12'(i)};
			send_save(k);
			if (i % 16 == 15)
				send_lookup();
		end
		// Saves while the table is full, of keys that are mostly not yet stored
		repeat (10) send_save({10'($urandom_range(0, 200) * 37), 12'($urandom_range(0, 200))});
		repeat (10) send_lookup();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		wait_all_done();
		@(posedge clk);
		hold_cycles = HOLD_CYCLES;
		repeat (8) send_random_op();
		wait_all_done();
		idle_on = 1'b1;
	endtask

	task automatic test_random_mix();
		logic [AGE_W-1:0] limits [5];
		limits[0] = MAX_AGE_RST;
		limits[1] = 8'd1;
		limits[2] = 8'($urandom_range(2, 253));
		limits[3] = 8'd254;
		limits[4] = 8'd4;
		for (int p = 0; p < 5; p++) begin
			set_max_age(limits[p]);
			idle_on = (p != 2);
			repeat (260) send_random_op();
			wait_all_done();
		end
		idle_on = 1'b1;
	endtask

	// Receiver: random stalls, plus a long hold on request
	initial begin
		int left;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else if (left > 0) begin
				out_stall = 1'b1;
				left--;
			end else begin
				out_stall = 1'b0;
				if (idle_on && $urandom_range(0, 3) == 0)
					left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				errors++;
				$error("result with nothing expected: status %0d", status);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					errors++;
					$error("status: expected %0d, actual %0d", want.st, status);
				end
				if (found_high !== want.fh) begin
					errors++;
					$error("found_high: expected %h, actual %h", want.fh, found_high);
				end
				if (found_low !== want.fl) begin
					errors++;
					$error("found_low: expected %h, actual %h", want.fl, found_low);
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_hi[i]    = '0;
			tbl_lo[i]    = '0;
			tbl_age[i]   = '0;
		end
		for (int i = 0; i < 6; i++)
			key_roots[i] = 10'($urandom);
		key_roots[0] = 10'h000;
		key_roots[1] = 10'h3FF;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_drop_at_zero();
		test_age_saturation();
		test_table_full();
		test_backpressure();
		test_random_mix();

		wait_all_done();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$error("%0d results never arrived", pending_results.size());
		end
		$display("covered %0d lookups (%0d hits), %0d saves (%0d refused as full),",
			n_lookup, n_hit, n_save, n_full);
		$display("%0d age ticks and %0d no-ops in %0d cycles, %0d errors",
			n_tick, n_nop, cycle_count, errors);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* callsign_hash_table_with_aging_core.f */
design/csht_pkg.sv
design/csht_ctrl.sv
design/csht_datapath.sv
design/callsign_hash_table_with_aging_core.sv
tb/sv/tb_callsign_hash_table_with_aging_core.sv
